FILE: rtl/rrcs_pkg.sv
// Shared types and constants of the round-robin cooldown scheduler.
`default_nettype none

package rrcs_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
  localparam int MASK_W      = 64;
  localparam int SLOT_FLD_W  = 6;
  localparam int COOL_W      = 8;
  localparam int REFRESH_W   = 16;
  localparam int TURN_W      = 10;
  localparam logic [TURN_W-1:0] TURN_LIMIT = 10'd999;

  localparam logic [7:0]  INTERVAL_RST = 8'd30;
  localparam logic [15:0] REFRESH_RST  = 16'd600;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_REFRESH  = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic                  map_idle;
    logic [MASK_W-1:0]     ready_mask;
    logic [SLOT_FLD_W-1:0] done_slot;
  } rrcs_in_t;

  typedef struct packed {
    logic                  grant_valid;
    logic [SLOT_FLD_W-1:0] grant_slot;
    logic [TURN_W-1:0]     turn_count;
  } rrcs_out_t;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_RUN,
    OP_DONE
  } rrcs_op_kind_t;

  typedef struct packed {
    rrcs_op_kind_t     kind;
    logic              done_ok;
    logic [MASK_W-1:0] ready_mask;
    logic [SLOT_W-1:0] done_slot;
  } rrcs_op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SWEEP,
    B_RESULT
  } rrcs_bstate_t;

endpackage

`default_nettype wire

FILE: rtl/rrcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rrcs_front.sv
// Front end: accepts input transfers, classifies them, two-entry queue.
`default_nettype none

module rrcs_front import rrcs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire rrcs_in_t in_data,
  output      logic     q_valid,
  output      rrcs_op_t q_op,
  input  wire logic     q_pop
);

  rrcs_op_t   entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;
  logic       push;
  logic       pop;
  rrcs_op_t   op_in;

  always_comb begin
    op_in.ready_mask = in_data.ready_mask;
    op_in.done_slot  = SLOT_W'(in_data.done_slot);
    op_in.done_ok    = ({1'b0, in_data.done_slot} < (SLOT_FLD_W + 1)'(NUM_SLOTS));
    if (in_data.req_type) begin
      op_in.kind = OP_DONE;
    end else if (in_data.map_idle) begin
      op_in.kind = OP_RUN;
    end else begin
      op_in.kind = OP_SKIP;
    end
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_op     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rrcs_back.sv
// Back end: timers, cooldown sweep with round-robin pick, result register.
`default_nettype none

module rrcs_back import rrcs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [COOL_W-1:0]    interval_frames,
  input  wire logic [REFRESH_W-1:0] refresh_frames,
  input  wire logic                 q_valid,
  input  wire rrcs_op_t             q_op,
  output      logic                 q_pop,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      rrcs_out_t            out_data
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  rrcs_bstate_t         state_r, state_nxt;
  rrcs_op_t             op_r, op_nxt;
  logic                 refresh_hit_r, refresh_hit_nxt;
  logic                 sched_hit_r, sched_hit_nxt;
  logic [COOL_W-1:0]    sched_timer_r, sched_timer_nxt;
  logic [REFRESH_W-1:0] refresh_timer_r, refresh_timer_nxt;
  logic [TURN_W-1:0]    turn_r, turn_nxt;
  logic [SLOT_W-1:0]    next_slot_r, next_slot_nxt;
  logic [CNT_W-1:0]     iss_cnt_r, iss_cnt_nxt;
  logic [SLOT_W-1:0]    iss_addr_r, iss_addr_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic [SLOT_W-1:0]    p_addr_r, p_addr_nxt;
  logic                 found_r, found_nxt;
  logic [SLOT_W-1:0]    gslot_r, gslot_nxt;
  logic [NUM_SLOTS-1:0] vld_r, vld_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rrcs_out_t            out_data_r, out_data_nxt;

  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [COOL_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [COOL_W-1:0]    ram_rdata;

  logic [COOL_W-1:0]    cool_old;
  logic [COOL_W-1:0]    cool_new;

  rrcs_ram #(
    .WIDTH (COOL_W),
    .DEPTH (NUM_SLOTS)
  ) u_cool_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Cooldown of the slot in the write-back stage; unwritten entries are zero.
  always_comb begin
    cool_old = vld_r[p_addr_r] ? ram_rdata : '0;
    if (refresh_hit_r || (cool_old == '0)) begin
      cool_new = '0;
    end else begin
      cool_new = cool_old - COOL_W'(1);
    end
  end

  always_comb begin
    state_nxt         = state_r;
    op_nxt            = op_r;
    refresh_hit_nxt   = refresh_hit_r;
    sched_hit_nxt     = sched_hit_r;
    sched_timer_nxt   = sched_timer_r;
    refresh_timer_nxt = refresh_timer_r;
    turn_nxt          = turn_r;
    next_slot_nxt     = next_slot_r;
    iss_cnt_nxt       = iss_cnt_r;
    iss_addr_nxt      = iss_addr_r;
    p_vld_nxt         = 1'b0;
    p_addr_nxt        = p_addr_r;
    found_nxt         = found_r;
    gslot_nxt         = gslot_r;
    vld_nxt           = vld_r;
    out_valid_nxt     = out_valid_r;
    out_data_nxt      = out_data_r;
    q_pop             = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = p_addr_r;
    ram_wdata         = cool_new;
    ram_re            = 1'b0;
    ram_raddr         = iss_addr_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_op;
          found_nxt = 1'b0;
          gslot_nxt = '0;
          state_nxt = B_RESULT;
          case (q_op.kind)
            OP_DONE: begin
              if (q_op.done_ok) begin
                ram_we             = 1'b1;
                ram_waddr          = q_op.done_slot;
                ram_wdata          = interval_frames;
                vld_nxt[q_op.done_slot] = 1'b1;
              end
            end
            OP_RUN: begin
              refresh_hit_nxt = (refresh_timer_r == '0);
              sched_hit_nxt   = (sched_timer_r == '0);
              if (refresh_timer_r == '0) begin
                refresh_timer_nxt = refresh_frames;
                if (turn_r < TURN_LIMIT) begin
                  turn_nxt = turn_r + TURN_W'(1);
                end
              end else begin
                refresh_timer_nxt = refresh_timer_r - REFRESH_W'(1);
              end
              if (sched_timer_r == '0) begin
                sched_timer_nxt = interval_frames;
              end else begin
                sched_timer_nxt = sched_timer_r - COOL_W'(1);
              end
              iss_cnt_nxt  = '0;
              iss_addr_nxt = (next_slot_r > LAST_SLOT) ? '0 : next_slot_r;
              state_nxt    = B_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end

      B_SWEEP: begin
        // Issue stage: one read per cycle in round-robin order.
        if (iss_cnt_r != CNT_W'(NUM_SLOTS)) begin
          ram_re       = 1'b1;
          ram_raddr    = iss_addr_r;
          p_vld_nxt    = 1'b1;
          p_addr_nxt   = iss_addr_r;
          iss_cnt_nxt  = iss_cnt_r + CNT_W'(1);
          iss_addr_nxt = (iss_addr_r == LAST_SLOT) ? '0 : iss_addr_r + SLOT_W'(1);
        end
        // Write-back stage: store updated cooldown, first eligible slot wins.
        if (p_vld_r) begin
          ram_we           = 1'b1;
          ram_waddr        = p_addr_r;
          ram_wdata        = cool_new;
          vld_nxt[p_addr_r] = 1'b1;
          if (sched_hit_r && !found_r && op_r.ready_mask[p_addr_r] &&
              (cool_new == '0)) begin
            found_nxt     = 1'b1;
            gslot_nxt     = p_addr_r;
            next_slot_nxt = (p_addr_r == LAST_SLOT) ? '0 : p_addr_r + SLOT_W'(1);
          end
        end
        if ((iss_cnt_r == CNT_W'(NUM_SLOTS)) && !p_vld_r) begin
          state_nxt = B_RESULT;
        end
      end

      B_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.grant_valid = found_r;
          out_data_nxt.grant_slot  = SLOT_FLD_W'(gslot_r);
          out_data_nxt.turn_count  = turn_r;
          state_nxt                = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= B_IDLE;
      sched_timer_r   <= '0;
      refresh_timer_r <= '0;
      turn_r          <= '0;
      next_slot_r     <= '0;
      iss_cnt_r       <= '0;
      p_vld_r         <= 1'b0;
      found_r         <= 1'b0;
      vld_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      sched_timer_r   <= sched_timer_nxt;
      refresh_timer_r <= refresh_timer_nxt;
      turn_r          <= turn_nxt;
      next_slot_r     <= next_slot_nxt;
      iss_cnt_r       <= iss_cnt_nxt;
      p_vld_r         <= p_vld_nxt;
      found_r         <= found_nxt;
      vld_r           <= vld_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    refresh_hit_r <= refresh_hit_nxt;
    sched_hit_r   <= sched_hit_nxt;
    iss_addr_r    <= iss_addr_nxt;
    p_addr_r      <= p_addr_nxt;
    gslot_r       <= gslot_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/round_robin_cooldown_scheduler.sv
// Top level of the round-robin cooldown scheduler: config registers, front, back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------
//   in_     | input     | in_valid / in_stall   | rrcs_in_t  (req, idle, mask, slot)
//   out_    | output    | out_valid / out_stall | rrcs_out_t (grant, slot, turns)
//   config  | input     | APB psel/penable      | interval_frames, refresh_frames
//
// Sweep: an idle tick sweeps all NUM_SLOTS slots through the single-port-read
//   cooldown RAM, one slot a cycle. A done request or a non-idle tick skips the
//   sweep and goes straight to the result stage.
// Reset: rst_n is synchronous; cooldowns read as zero until written (valid bits),
//   no clearing pass.
// Stalls: a two-entry queue takes input transfers while the back end works and
//   while a finished result waits in the output register.
`default_nettype none

module round_robin_cooldown_scheduler import rrcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire rrcs_in_t          in_data,
  // result channel
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      rrcs_out_t         out_data,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready
);

  logic [COOL_W-1:0]    interval_r, interval_nxt;
  logic [REFRESH_W-1:0] refresh_r,  refresh_nxt;
  logic                 cfg_wr;
  logic                 q_valid;
  rrcs_op_t             q_op;
  logic                 q_pop;

  // Register i sits at byte address 4*i; paddr[2] picks the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    interval_nxt = interval_r;
    refresh_nxt  = refresh_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_INTERVAL: interval_nxt = pwdata[COOL_W-1:0];
        REG_REFRESH:  refresh_nxt  = pwdata[REFRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INTERVAL: prdata = CFG_DW'(interval_r);
      REG_REFRESH:  prdata = CFG_DW'(refresh_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      refresh_r  <= REFRESH_RST;
    end else begin
      interval_r <= interval_nxt;
      refresh_r  <= refresh_nxt;
    end
  end

  // Front: takes transfers, tags them as run tick, skipped tick or done.
  rrcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop)
  );

  // Back: timers, cooldown sweep, round-robin pick, result register.
  rrcs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .interval_frames (interval_r),
    .refresh_frames  (refresh_r),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/rrcs_checker.sv
// Port-level checks for the round-robin cooldown scheduler, bound to the top.
`default_nettype none

module rrcs_checker import rrcs_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire rrcs_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_grant_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.grant_valid |-> out_data.grant_slot == '0)
    else $error("grant slot nonzero without grant");

  a_turn_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.turn_count <= TURN_LIMIT)
    else $error("turn count above limit");

  a_turn_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n) |->
      out_data.turn_count >= $past(out_data.turn_count))
    else $error("turn count went down");

endmodule

bind round_robin_cooldown_scheduler rrcs_checker u_rrcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: dv/rrcs_grant_checker.sv
// Request codes and the grant checker of the round-robin cooldown scheduler bench.

package rrcs_tb_pkg;

  // req_type encoding
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_DONE = 1'b1;

endpackage

module rrcs_grant_checker import rrcs_pkg::*, rrcs_tb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  rrcs_in_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rrcs_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic [CFG_DW-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // scheduler state as the block should hold it
  logic [7:0]           interval_cfg;
  logic [REFRESH_W-1:0] refresh_cfg;
  logic [COOL_W-1:0]    slot_cool [NUM_SLOTS];
  logic [7:0]           sched_tmr;
  logic [REFRESH_W-1:0] refresh_tmr;
  logic [SLOT_W-1:0]    rr_ptr;
  logic [TURN_W-1:0]    turns;

  rrcs_out_t grant_q [$];

  // One request: done loads a cooldown; idle tick sweeps, refreshes and searches.
  function automatic rrcs_out_t advance_schedule(input rrcs_in_t req);
    rrcs_out_t res;
    int        first;
    int        s;
    res = '0;
    if (req.req_type == REQ_DONE) begin
      if (req.done_slot < NUM_SLOTS) slot_cool[req.done_slot] = interval_cfg;
    end else if (req.map_idle) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (slot_cool[k] != '0) slot_cool[k] = slot_cool[k] - 1'b1;
      end
      if (refresh_tmr != '0) begin
        refresh_tmr = refresh_tmr - 1'b1;
      end else begin
        refresh_tmr = refresh_cfg;
        for (int k = 0; k < NUM_SLOTS; k++) slot_cool[k] = '0;
        if (turns < TURN_LIMIT) turns = turns + 1'b1;
      end
      if (sched_tmr != '0) begin
        sched_tmr = sched_tmr - 1'b1;
      end else begin
        sched_tmr = interval_cfg;
        first = (rr_ptr >= NUM_SLOTS) ? 0 : int'(rr_ptr);
        for (int k = 0; k < NUM_SLOTS && !res.grant_valid; k++) begin
          s = (first + k) % NUM_SLOTS;
          if (req.ready_mask[s] && slot_cool[s] == '0) begin
            res.grant_valid = 1'b1;
            res.grant_slot  = SLOT_FLD_W'(s);
            rr_ptr          = (s + 1 == NUM_SLOTS) ? '0 : SLOT_W'(s + 1);
          end
        end
      end
    end
    res.turn_count = turns;
    return res;
  endfunction

  always @(posedge clk) begin
    rrcs_out_t         want;
    logic [CFG_DW-1:0] cfg_val;
    if (!rst_n) begin
      interval_cfg = INTERVAL_RST;
      refresh_cfg  = REFRESH_RST;
      for (int k = 0; k < NUM_SLOTS; k++) slot_cool[k] = '0;
      sched_tmr   = '0;
      refresh_tmr = '0;
      rr_ptr      = '0;
      turns       = '0;
      fail_count  = 0;
      grant_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[CFG_AW-1:2] == REG_INTERVAL) interval_cfg = pwdata[7:0];
          else refresh_cfg = pwdata[REFRESH_W-1:0];
        end else begin
          cfg_val = (paddr[CFG_AW-1:2] == REG_INTERVAL) ? CFG_DW'(interval_cfg)
                                                       : CFG_DW'(refresh_cfg);
          if (prdata !== cfg_val) begin
            $error("prdata: expected 0x%0h, got 0x%0h", cfg_val, prdata);
            fail_count++;
          end
        end
      end

      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $error("result with nothing outstanding: grant_valid=%0d grant_slot=%0d turn_count=%0d",
                 out_data.grant_valid, out_data.grant_slot, out_data.turn_count);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (out_data.grant_valid !== want.grant_valid) begin
            $error("grant_valid: expected %0d, got %0d", want.grant_valid, out_data.grant_valid);
            fail_count++;
          end
          if (out_data.grant_slot !== want.grant_slot) begin
            $error("grant_slot: expected %0d, got %0d", want.grant_slot, out_data.grant_slot);
            fail_count++;
          end
          if (out_data.turn_count !== want.turn_count) begin
            $error("turn_count: expected %0d, got %0d", want.turn_count, out_data.turn_count);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) grant_q.push_back(advance_schedule(in_data));
    end
    pending = grant_q.size();
  end

endmodule

FILE: dv/tb_round_robin_cooldown_scheduler.sv
// Top of the round-robin cooldown scheduler bench: clock, reset, stimulus and verdict.

module tb_round_robin_cooldown_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import rrcs_pkg::*;
  import rrcs_tb_pkg::*;

  // Generous bound: ~1400 requests plus stalls stay well below.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Idle ticks at refresh_frames 0 needed to push turn_count into saturation;
  // the margin covers a refresh timer still draining from the previous setting.
  localparam int SAT_TICKS    = 1030;
  // Quiet cycles at the end, about one idle tick's worth of block latency plus slack.
  localparam int DRAIN_CYCLES = 100;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rrcs_in_t          in_data;
  logic              out_valid;
  logic              out_stall;
  rrcs_out_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int          fail_count;
  int          grants_pending;
  int          src_idle_pct  = 0;   // chance per cycle that the sender holds off
  int          sink_idle_pct = 0;   // chance per cycle that the receiver stalls
  int          win_base;            // base of the small slot window requests focus on
  int          sat_ticks;           // idle ticks sent while refresh_frames is 0
  int unsigned cycles = 0;

  round_robin_cooldown_scheduler dut (.*);

  rrcs_grant_checker u_grant_chk (.pending(grants_pending), .*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("round_robin_cooldown_scheduler: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle from the current stall rate.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  // One transfer on the request channel. Entered and left at a falling edge;
  // valid is only lowered in a gap, so back-to-back items keep it high.
  task automatic send_item(input rrcs_in_t item);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_req(input logic req, input logic idle,
                          input logic [MASK_W-1:0] mask,
                          input logic [SLOT_FLD_W-1:0] slot);
    rrcs_in_t item;
    item.req_type   = req;
    item.map_idle   = idle;
    item.ready_mask = mask;
    item.done_slot  = slot;
    send_item(item);
  endtask

  // Wait until every request sent so far has had its result taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (grants_pending != 0) @(negedge clk);
  endtask

  // APB access: setup cycle, access cycle, then a quiet gap with psel low so the next
  // access never lowers and raises psel in the same step.
  task automatic cfg_access(input logic wr, input logic reg_sel,
                            input logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Only called with the block idle; each write is read back.
  task automatic set_timing(input logic [7:0] ivl, input logic [REFRESH_W-1:0] rfr);
    drain();
    cfg_access(1'b1, REG_INTERVAL, CFG_DW'(ivl));
    cfg_access(1'b1, REG_REFRESH, CFG_DW'(rfr));
    cfg_access(1'b0, REG_INTERVAL, '0);
    cfg_access(1'b0, REG_REFRESH, '0);
  endtask

  // Random requests under one timing setting. Most ready masks and done slots
  // come from a small window of slots, so grants, done transfers and cooldowns
  // hit the same slots and the cooldown actually blocks searches; the rest are
  // wide random masks, all-ones, empty and single-slot masks.
  task automatic run_segment(input logic [7:0] ivl, input logic [REFRESH_W-1:0] rfr,
                             input int count, input bit to_saturation);
    rrcs_in_t item;
    int       sent;
    int       roll;
    int       tick_pct;
    set_timing(ivl, rfr);
    tick_pct = to_saturation ? 95 : 60;
    sent = 0;
    while (sent < count || (to_saturation && sat_ticks < SAT_TICKS)) begin
      if (sent % 64 == 0) win_base = $urandom_range(0, NUM_SLOTS - 1);

      item.ready_mask = '0;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        for (int k = 0; k < 8; k++) begin
          if ($urandom_range(0, 1) == 1) item.ready_mask[(win_base + k) % NUM_SLOTS] = 1'b1;
        end
      end else if (roll < 80) begin
        item.ready_mask = {$urandom, $urandom};
      end else if (roll < 88) begin
        item.ready_mask = '1;
      end else if (roll >= 94) begin
        item.ready_mask[$urandom_range(0, NUM_SLOTS - 1)] = 1'b1;
      end

      if ($urandom_range(0, 99) < 70)
        item.done_slot = SLOT_FLD_W'((win_base + $urandom_range(0, 7)) % NUM_SLOTS);
      else
        item.done_slot = SLOT_FLD_W'($urandom_range(0, 63));

      // idle ticks dominate; the rest split between busy ticks and done transfers
      item.map_idle = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (roll < tick_pct) begin
        item.req_type = REQ_TICK;
        item.map_idle = 1'b1;
      end else if (roll < tick_pct + (100 - tick_pct) / 3) begin
        item.req_type = REQ_TICK;
        item.map_idle = 1'b0;
      end else begin
        item.req_type = REQ_DONE;
      end

      if (rfr == '0 && item.req_type == REQ_TICK && item.map_idle) sat_ticks++;
      send_item(item);
      sent++;
    end
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    rst_n     = 1'b0;
    win_base  = 0;
    sat_ticks = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First idling mode: sender mostly busy, receiver stalling a lot.
    src_idle_pct  = 24;
    sink_idle_pct = 79;

    // Registers must read back their reset values.
    cfg_access(1'b0, REG_INTERVAL, '0);
    cfg_access(1'b0, REG_REFRESH, '0);

    // Reset timing: done transfers load the reset interval whatever map_idle
    // says; ticks while the map is busy change nothing.
    send_req(REQ_DONE, 1'b0, '0, 6'd0);
    send_req(REQ_DONE, 1'b1, '1, 6'd63);
    send_req(REQ_TICK, 1'b0, '1, 6'd0);
    send_req(REQ_TICK, 1'b0, '0, 6'd63);

    // Zero interval: a search on every idle tick and no cooldown after done.
    // The first idle tick also hits the expired refresh timer and clears all.
    set_timing(8'd0, 16'd20);
    send_req(REQ_TICK, 1'b1, '1, 6'd0);                      // slot 0
    send_req(REQ_TICK, 1'b1, '1, 6'd0);                      // slot 1
    send_req(REQ_TICK, 1'b1, '0, 6'd0);                      // nothing eligible
    send_req(REQ_TICK, 1'b1, 64'h1, 6'd0);                   // search wraps to 0
    send_req(REQ_TICK, 1'b1, 64'h8000_0000_0000_0000, 6'd0); // last slot, pointer wraps
    send_req(REQ_TICK, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0);
    send_req(REQ_TICK, 1'b1, 64'h5555_5555_5555_5555, 6'd0);
    send_req(REQ_DONE, 1'b1, '0, 6'd4);
    send_req(REQ_TICK, 1'b1, 64'h10, 6'd0);                  // no cooldown, slot 4 wins

    // Short interval: a cooling slot is skipped, then granted once it expires.
    set_timing(8'd2, 16'hFFFF);
    send_req(REQ_DONE, 1'b0, '0, 6'd7);
    send_req(REQ_TICK, 1'b1, 64'h280, 6'd0);                 // 7 cooling, 9 granted
    send_req(REQ_TICK, 1'b1, '1, 6'd0);
    send_req(REQ_TICK, 1'b1, '1, 6'd0);
    send_req(REQ_TICK, 1'b1, 64'h80, 6'd0);                  // 7 free again
    send_req(REQ_TICK, 1'b0, 64'h80, 6'd0);

    // Random part, sender/receiver rates as above.
    run_segment(8'd0, 16'd0, 100, 1'b0);

    // Second idling mode: swapped rates.
    src_idle_pct  = 79;
    sink_idle_pct = 24;
    // refresh every idle tick until turn_count has sat at its limit for a while
    run_segment(8'd0, 16'd0, 100, 1'b1);
    run_segment(8'd3, 16'd40, 60, 1'b0);
    run_segment(8'($urandom_range(1, 20)), 16'($urandom_range(0, 60)), 60, 1'b0);

    // No idling on either side.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_segment(8'($urandom_range(1, 8)), 16'($urandom_range(50, 200)), 60, 1'b0);
    run_segment(8'd255, 16'hFFFF, 40, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("round_robin_cooldown_scheduler: match");
    end else begin
      $display("round_robin_cooldown_scheduler: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rrcs_pkg.sv
rtl/rrcs_ram.sv
rtl/rrcs_front.sv
rtl/rrcs_back.sv
rtl/round_robin_cooldown_scheduler.sv
rtl/rrcs_checker.sv
dv/rrcs_grant_checker.sv
dv/tb_round_robin_cooldown_scheduler.sv
